// ===== sv/binomial_coefficient_macros.svh =====
// ----------------------------------------------------------------------------
// Binomial coefficient assertion macros
// Wrappers for concurrent assertions. They compile to nothing when ASSERT_OFF
// is set.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_COEFFICIENT_MACROS_SVH
`define BINOMIAL_COEFFICIENT_MACROS_SVH

`ifndef ASSERT_OFF
// The condition a implies c in the same cycle.
`define BC_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error(msg);
// The condition a implies c in the next cycle.
`define BC_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error(msg);
`else
`define BC_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define BC_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif

`endif

// ===== sv/bc_pkg.sv =====
// ----------------------------------------------------------------------------
// Binomial coefficient package
// Widths and limits shared by the interfaces and the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bc_pkg;

	// Width of the n and k fields.
	localparam int N_W = 5;
	// Width of the result field.
	localparam int COEF_W = 18;
	// Width of the factorial datapath; 20! fits below 2**63.
	localparam int FACT_W = 64;
	// Largest index the datapath can hold without overflow.
	localparam int HARD_LIMIT = 20;
	// Default for the top level MAX_N parameter.
	localparam int DEFAULT_MAX_N = 20;

endpackage

// ===== sv/bc_if.sv =====
// ----------------------------------------------------------------------------
// Binomial coefficient channel interfaces
// Valid/ready channels for the operand and the result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bc_in_if import bc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [N_W-1:0]  n;
	logic [N_W-1:0]  k;

	modport source (output valid, output n, output k, input ready);
	modport sink (input valid, input n, input k, output ready);
endinterface

interface bc_out_if import bc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COEF_W-1:0] coefficient;

	modport source (output valid, output coefficient, input ready);
	modport sink (input valid, input coefficient, output ready);
endinterface

// ===== sv/bc_mul.sv =====
// ----------------------------------------------------------------------------
// Binomial coefficient multiplier
// Multiplies a factorial accumulator by one small factor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bc_mul import bc_pkg::*; (
	input  logic [FACT_W-1:0] acc,
	input  logic [N_W-1:0]    factor,
	output logic [FACT_W-1:0] prod
);

	logic [FACT_W+N_W-1:0] prod_full;

	// The full product never exceeds the datapath width for legal indexes.
	assign prod_full = {{N_W{1'b0}}, acc} * {{FACT_W{1'b0}}, factor};
	assign prod = prod_full[FACT_W-1:0];

endmodule

// ===== sv/bc_divider.sv =====
// ----------------------------------------------------------------------------
// Binomial coefficient divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bc_divider import bc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FACT_W-1:0] dividend,
	input  logic [FACT_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [COEF_W-1:0] quotient
);

	localparam int CNT_W = $clog2(FACT_W + 1);

	logic [FACT_W-1:0] rem_q;
	logic [FACT_W-1:0] dvd_q;
	logic [FACT_W-1:0] dvs_q;
	logic [COEF_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [FACT_W:0]   trial;
	logic [FACT_W:0]   diff;
	logic              fits;

	assign trial = {rem_q, dvd_q[FACT_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= CNT_W'(FACT_W);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				busy_q <= (cnt_q != CNT_W'(1));
				done_q <= (cnt_q == CNT_W'(1));
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// Only the low quotient bits are kept; the true quotient fits in them.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[FACT_W-2:0], 1'b0};
			if (fits) begin
				rem_q <= diff[FACT_W-1:0];
			end else begin
				rem_q <= trial[FACT_W-1:0];
			end
			quo_q <= {quo_q[COEF_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/binomial_coefficient.sv =====
// An operand pair runs through the three factorials and the division, then waits
// in ST_WAIT for the output register; a pair with k above n goes from ST_IDLE
// straight to ST_WAIT and returns 0. A new pair is taken only after the result of
// the last one is loaded, with ready back in the cycle after the load; the bit-serial
// divider and the shared 64x5 multiplier, used once per factor, set the pace.
// Reset: arst_n clears the sequencer and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Binomial coefficient
// Computes n choose k as n! / (k! * (n-k)!) with one shared multiplier and an
// iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "binomial_coefficient_macros.svh"

module binomial_coefficient import bc_pkg::*; #(
	parameter int MAX_N = DEFAULT_MAX_N
) (
	input  logic        clk,
	input  logic        arst_n,
	bc_in_if.sink       operands,
	bc_out_if.source    result
);

	// Indexes are clamped to the smaller of MAX_N and the datapath limit.
	localparam int LIM = (MAX_N > HARD_LIMIT) ? HARD_LIMIT : MAX_N;
	localparam logic [N_W-1:0] LIM_V = N_W'(LIM);

	// The sequencer runs the three factorials, then the division; k above n skips them.
	// Every factorial is built one factor per cycle on the same multiplier.
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_NUM   = 6'b000010,
		ST_DEN_K = 6'b000100,
		ST_DEN_R = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_WAIT  = 6'b100000
	} bc_state_t;

	bc_state_t         state_q;
	logic [N_W-1:0]    cnt_q;
	logic [N_W-1:0]    k_q;
	logic [N_W-1:0]    r_q;
	logic [FACT_W-1:0] num_q;
	logic [FACT_W-1:0] den_q;
	logic [COEF_W-1:0] quot_q;
	logic              out_valid_q;
	logic [COEF_W-1:0] coef_q;

	logic [N_W-1:0]    n_sat;
	logic [N_W-1:0]    k_sat;
	logic              in_acc;
	logic              out_free;
	logic [FACT_W-1:0] mul_acc;
	logic [FACT_W-1:0] mul_prod;
	logic              div_start;
	logic              div_busy;
	logic              div_done;
	logic [COEF_W-1:0] div_quot;

	// Out-of-range indexes saturate before use, and k is compared after that.
	assign n_sat = (operands.n > LIM_V) ? LIM_V : operands.n;
	assign k_sat = (operands.k > LIM_V) ? LIM_V : operands.k;

	assign operands.ready = (state_q == ST_IDLE);
	assign in_acc         = operands.valid && operands.ready;

	// The output register frees the core as soon as a result is parked there.
	assign out_free = !out_valid_q || result.ready;

	// The multiplier works on the numerator first and on the denominator after.
	assign mul_acc = (state_q == ST_NUM) ? num_q : den_q;

	bc_mul u_mul (
		.acc    (mul_acc),
		.factor (cnt_q),
		.prod   (mul_prod)
	);

	assign div_start = (state_q == ST_DEN_R) && (cnt_q == '0);

	bc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (den_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (k_sat > n_sat) ? ST_WAIT : ST_NUM;
					end
				end
				ST_NUM: begin
					if (cnt_q == '0) begin
						state_q <= ST_DEN_K;
					end
				end
				ST_DEN_K: begin
					if (cnt_q == '0) begin
						state_q <= ST_DEN_R;
					end
				end
				ST_DEN_R: begin
					if (cnt_q == '0) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers. Each factorial counts its factor down to zero and
	// multiplies by it on the way; a zero count hands over to the next one or the divider.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cnt_q  <= n_sat;
					k_q    <= k_sat;
					r_q    <= n_sat - k_sat;
					num_q  <= FACT_W'(1);
					den_q  <= FACT_W'(1);
					quot_q <= '0;
				end
			end
			ST_NUM: begin
				if (cnt_q == '0) begin
					cnt_q <= k_q;
				end else begin
					num_q <= mul_prod;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_DEN_K: begin
				if (cnt_q == '0) begin
					cnt_q <= r_q;
				end else begin
					den_q <= mul_prod;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_DEN_R: begin
				if (cnt_q != '0) begin
					den_q <= mul_prod;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					quot_q <= div_quot;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: cleared when taken, reloaded when a result is ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_WAIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_WAIT) && out_free) begin
			coef_q <= quot_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.coefficient = coef_q;

	// A pair with k above n skips the datapath and yields a zero result.
	`BC_ASSERT_NXT(a_k_above_n_zero, clk, arst_n, in_acc && (k_sat > n_sat),
		(state_q == ST_WAIT) && (quot_q == '0), "k above n did not yield zero")
	// The divider is never restarted while it still works on a quotient.
	`BC_ASSERT_IMP(a_div_start_idle, clk, arst_n, div_start, !div_busy,
		"divider started while busy")
	// The denominator never collapses to zero while the datapath is active.
	`BC_ASSERT_IMP(a_den_nonzero, clk, arst_n,
		(state_q == ST_DEN_K) || (state_q == ST_DEN_R) || (state_q == ST_DIV),
		den_q != '0, "denominator reached zero")

endmodule

// ===== tb/sv/binomial_coefficient_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binomial coefficient testbench
// Sends (n, k) operand pairs to the block and compares every returned
// coefficient with a value worked out here from factorials. A directed set
// covers the range edges, k above n and indexes past the saturation point.
// Random pairs follow under four flow-control phases: no idling, heavy
// operand idling, heavy result stalling, and light idling and stalling on both.
// ----------------------------------------------------------------------------

module binomial_coefficient_tb;
	import bc_pkg::*;

	// Index limit of the instance; the model saturates n and k to this value.
	localparam int MAX_N = DEFAULT_MAX_N;
	// Random operand pairs per flow-control phase.
	localparam int RANDOM_PER_PHASE = 357;
	// Number of flow-control phases.
	localparam int PHASE_COUNT = 4;
	// Cycles to wait after the last result.
	localparam int DRAIN_CYCLES = 300;
	// Hard stop for the whole run, many times the slowest correct run.
	localparam int CYCLE_LIMIT = 2000000;

	// One operand transaction as the driver sends it.
	typedef struct packed {
		logic [N_W-1:0] n;
		logic [N_W-1:0] k;
	} operand_pair_t;

	// One coefficient the block still owes, together with its operands so
	// that a mismatch can be traced back to the pair that caused it.
	typedef struct packed {
		logic [N_W-1:0]    n;
		logic [N_W-1:0]    k;
		logic [COEF_W-1:0] coefficient;
	} coef_due_t;

	logic clk;
	logic arst_n;

	bc_in_if  operands_if ();
	bc_out_if result_if ();

	binomial_coefficient #(
		.MAX_N(MAX_N)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.operands(operands_if),
		.result(result_if)
	);

	// Pairs waiting to be driven, and coefficients waiting to come back.
	operand_pair_t pending_pairs[$];
	coef_due_t     coefs_due[$];
	operand_pair_t next_pair;

	// Percent of cycles in which the driver holds back and the receiver
	// stalls; the stimulus process sets both at each phase boundary.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	int unsigned cycle_count;
	int unsigned error_count;
	int unsigned pairs_sent;
	int unsigned coefs_checked;
	int unsigned zero_coefs;
	int unsigned saturated_pairs;

	// Factorial in a 64-bit datapath; 20! still fits.
	function automatic logic [63:0] factorial_of(int unsigned v);
		logic [63:0] acc;

		acc = 64'd1;
		for (int unsigned i = 2; i <= v; i++)
			acc = acc * 64'(i);
		return acc;
	endfunction

	// Expected coefficient for one operand pair. Both indexes saturate to the
	// limit first, and a k above n gives zero.
	function automatic logic [COEF_W-1:0] choose_of(logic [N_W-1:0] n_raw,
			logic [N_W-1:0] k_raw);
		int unsigned n_sat;
		int unsigned k_sat;
		logic [63:0] denom;
		logic [63:0] quot;

		n_sat = (n_raw > MAX_N) ? MAX_N : n_raw;
		k_sat = (k_raw > MAX_N) ? MAX_N : k_raw;
		if (k_sat > n_sat)
			return '0;
		denom = factorial_of(k_sat) * factorial_of(n_sat - k_sat);
		quot = (denom != 0) ? factorial_of(n_sat) / denom : 64'd0;
		return quot[COEF_W-1:0];
	endfunction

	// Random pair. Most pairs are in range with k at most n, so that the full
	// multiply and divide sequence runs; the rest have k above n or use the
	// whole five-bit field, which also exercises the saturation.
	function automatic operand_pair_t random_pair();
		operand_pair_t p;
		int unsigned pick;

		pick = $urandom_range(99);
		if (pick < 78) begin
			p.n = N_W'($urandom_range(MAX_N));
			p.k = N_W'($urandom_range(p.n));
		end else if (pick < 90) begin
			p.n = N_W'($urandom_range(MAX_N - 1));
			p.k = N_W'($urandom_range(MAX_N, p.n + 1));
		end else begin
			p.n = N_W'($urandom);
			p.k = N_W'($urandom);
		end
		return p;
	endfunction

	// Clock and the single reset pulse. The block's inputs get known values
	// at time zero, before the first clock edge.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		operands_if.valid = 1'b0;
		operands_if.n = '0;
		operands_if.k = '0;
		result_if.ready = 1'b0;
		fork
			forever #6 clk = ~clk;
			begin
				repeat (2) @(posedge clk);
				arst_n <= 1'b1;
			end
		join_none
	end

	// Operand driver. A pair stays on the channel until the block takes it.
	// When the channel is free the driver either offers the next pending pair
	// or idles for the cycle, as the current phase asks. Every accepted
	// transaction pushes its expected coefficient at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operands_if.valid <= 1'b0;
			operands_if.n <= '0;
			operands_if.k <= '0;
		end else begin
			if (operands_if.valid && operands_if.ready) begin
				coefs_due.push_back('{n: operands_if.n, k: operands_if.k,
					coefficient: choose_of(operands_if.n, operands_if.k)});
				pairs_sent++;
				if (operands_if.n > MAX_N || operands_if.k > MAX_N)
					saturated_pairs++;
			end
			if (!operands_if.valid || operands_if.ready) begin
				if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_pair = pending_pairs.pop_front();
					operands_if.n <= next_pair.n;
					operands_if.k <= next_pair.k;
					operands_if.valid <= 1'b1;
				end else begin
					operands_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: ready is redrawn each cycle from the stall rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_if.ready <= 1'b0;
		else
			result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Result monitor. Each accepted result transaction is matched against
	// the oldest coefficient still owed. A result with nothing owed is an
	// error as well.
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (coefs_due.size() == 0) begin
				$display("%0t ns: unexpected result, coefficient %0d with none pending",
					$time, result_if.coefficient);
				error_count++;
			end else begin
				if (result_if.coefficient !== coefs_due[0].coefficient) begin
					$display("%0t ns: coefficient mismatch for n=%0d k=%0d: expected %0d, got %0d",
						$time, coefs_due[0].n, coefs_due[0].k,
						coefs_due[0].coefficient, result_if.coefficient);
					error_count++;
				end
				if (coefs_due[0].coefficient == 0)
					zero_coefs++;
				coefs_checked++;
				void'(coefs_due.pop_front());
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, coefs_due.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned send_pct_tbl[PHASE_COUNT];
		int unsigned recv_pct_tbl[PHASE_COUNT];

		send_pct_tbl = '{0, 76, 0, 11};
		recv_pct_tbl = '{0, 0, 76, 11};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cycle_count = 0;
		error_count = 0;
		pairs_sent = 0;
		coefs_checked = 0;
		zero_coefs = 0;
		saturated_pairs = 0;

		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed pairs: both indexes zero, k equal to zero or to n, the
		// largest coefficient at n = 20 and k = 10, k above n, and indexes
		// past the limit that saturate down to it (including all ones).
		pending_pairs.push_back('{n: 5'd0,  k: 5'd0});
		pending_pairs.push_back('{n: 5'd1,  k: 5'd0});
		pending_pairs.push_back('{n: 5'd1,  k: 5'd1});
		pending_pairs.push_back('{n: 5'd20, k: 5'd10});
		pending_pairs.push_back('{n: 5'd20, k: 5'd0});
		pending_pairs.push_back('{n: 5'd20, k: 5'd20});
		pending_pairs.push_back('{n: 5'd20, k: 5'd1});
		pending_pairs.push_back('{n: 5'd20, k: 5'd19});
		pending_pairs.push_back('{n: 5'd19, k: 5'd9});
		pending_pairs.push_back('{n: 5'd17, k: 5'd8});
		pending_pairs.push_back('{n: 5'd7,  k: 5'd3});
		pending_pairs.push_back('{n: 5'd3,  k: 5'd2});
		pending_pairs.push_back('{n: 5'd0,  k: 5'd1});
		pending_pairs.push_back('{n: 5'd0,  k: 5'd20});
		pending_pairs.push_back('{n: 5'd5,  k: 5'd7});
		pending_pairs.push_back('{n: 5'd1,  k: 5'd20});
		pending_pairs.push_back('{n: 5'd19, k: 5'd20});
		pending_pairs.push_back('{n: 5'd31, k: 5'd31});
		pending_pairs.push_back('{n: 5'd31, k: 5'd10});
		pending_pairs.push_back('{n: 5'd31, k: 5'd0});
		pending_pairs.push_back('{n: 5'd10, k: 5'd31});
		pending_pairs.push_back('{n: 5'd21, k: 5'd20});
		pending_pairs.push_back('{n: 5'd25, k: 5'd21});
		pending_pairs.push_back('{n: 5'd20, k: 5'd21});

		// Each phase queues its random pairs and then lets the block drain
		// before the idling pattern changes, so every phase starts clean.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			send_idle_pct <= send_pct_tbl[ph];
			recv_stall_pct <= recv_pct_tbl[ph];
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				pending_pairs.push_back(random_pair());
			@(posedge clk);
			while (pending_pairs.size() != 0 || operands_if.valid || coefs_due.size() != 0)
				@(posedge clk);
		end

		// Give a straggling extra result the chance to show up.
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (coefs_due.size() != 0) begin
			$display("%0t ns: %0d expected results never arrived", $time, coefs_due.size());
			error_count++;
		end

		$display("Checked %0d coefficients for %0d operand pairs in %0d idling phases.",
			coefs_checked, pairs_sent, PHASE_COUNT);
		$display("Of these, %0d gave zero and %0d had an index past the limit; %0d errors.",
			zero_coefs, saturated_pairs, error_count);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/bc_pkg.sv
sv/bc_if.sv
sv/bc_mul.sv
sv/bc_divider.sv
sv/binomial_coefficient.sv
tb/sv/binomial_coefficient_tb.sv
